// ----- sv/frf_pkg.sv -----
package frf_pkg;

  // Request types carried on req_type.
  localparam logic [1:0] REQ_WRITE     = 2'd0;
  localparam logic [1:0] REQ_TRANSFORM = 2'd1;
  localparam logic [1:0] REQ_READ      = 2'd2;

  // Transform operations carried on op.
  localparam logic [1:0] OP_ROT_CW  = 2'd0;
  localparam logic [1:0] OP_ROT_CCW = 2'd1;
  localparam logic [1:0] OP_MIRROR  = 2'd2;
  localparam logic [1:0] OP_FLIP    = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [7:0] DIM_RESET = 8'd128;

  // Orientation bits: transpose, row mirror, column mirror.
  typedef struct packed {
    logic t;
    logic fr;
    logic fc;
  } orient_t;

  // One classified request handed from the front end to the back end.
  // The memory address travels next to it because its width follows
  // the frame size parameter.
  typedef struct packed {
    logic       is_read;
    logic       oor;
    logic [7:0] pixel;
    logic [7:0] height;
    logic [7:0] width;
  } cmd_t;

endpackage

// ----- sv/frf_front.sv -----
module frf_front
  import frf_pkg::*;
#(
  parameter int unsigned MAX_DIM = 128,
  parameter int unsigned IDX_W   = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           req_type,
  input  logic [6:0]           row,
  input  logic [6:0]           col,
  input  logic [7:0]           pixel,
  input  logic [1:0]           op,
  input  logic [7:0]           rows,
  input  logic [7:0]           cols,
  output logic                 push,
  output cmd_t                 push_cmd,
  output logic [2*IDX_W-1:0]   push_addr
);

  localparam logic [7:0] CAP = (MAX_DIM > 255) ? 8'd255 : 8'(MAX_DIM);

  orient_t orient;
  orient_t orient_next;

  logic [7:0] lr;
  logic [7:0] lc;
  logic [7:0] h;
  logic [7:0] w;
  logic [7:0] rp;
  logic [7:0] cp;
  logic [7:0] sr;
  logic [7:0] sc;
  logic       rd_in;
  logic       wr_in;

  always_comb begin
    lr = (rows == 8'd0) ? 8'd1 : ((rows > CAP) ? CAP : rows);
    lc = (cols == 8'd0) ? 8'd1 : ((cols > CAP) ? CAP : cols);
    h  = orient.t ? lc : lr;
    w  = orient.t ? lr : lc;

    rd_in = ({1'b0, row} < h) && ({1'b0, col} < w);
    wr_in = ({1'b0, row} < lr) && ({1'b0, col} < lc);

    rp = orient.fr ? 8'(h - 8'd1 - {1'b0, row}) : {1'b0, row};
    cp = orient.fc ? 8'(w - 8'd1 - {1'b0, col}) : {1'b0, col};
    sr = orient.t ? cp : rp;
    sc = orient.t ? rp : cp;

    push      = 1'b0;
    push_cmd  = '0;
    push_addr = '0;
    push_cmd.pixel  = pixel;
    push_cmd.height = h;
    push_cmd.width  = w;
    case (req_type)
      REQ_WRITE: begin
        push      = accept && wr_in;
        push_addr = {IDX_W'(row), IDX_W'(col)};
      end
      REQ_READ: begin
        push             = accept;
        push_cmd.is_read = 1'b1;
        push_cmd.oor     = !rd_in;
        push_addr        = {IDX_W'(sr), IDX_W'(sc)};
      end
      default: begin
        push = 1'b0;
      end
    endcase

    orient_next = orient;
    case (op)
      OP_ROT_CW: begin
        orient_next = '{t: !orient.t, fr: orient.fc, fc: !orient.fr};
      end
      OP_ROT_CCW: begin
        orient_next = '{t: !orient.t, fr: !orient.fc, fc: orient.fr};
      end
      OP_MIRROR: begin
        orient_next.fc = !orient.fc;
      end
      OP_FLIP: begin
        orient_next.fr = !orient.fr;
      end
      default: begin
        orient_next = orient;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orient <= '0;
    end else if (accept && (req_type == REQ_TRANSFORM)) begin
      orient <= orient_next;
    end
  end

endmodule

// ----- sv/frf_queue.sv -----
module frf_queue
  import frf_pkg::*;
#(
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cmd_t              push_cmd,
  input  logic [ADDR_W-1:0] push_addr,
  input  logic              pop,
  output cmd_t              pop_cmd,
  output logic [ADDR_W-1:0] pop_addr,
  output logic              empty,
  output logic              full
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = 2;

  cmd_t              cmd_q  [DEPTH];
  logic [ADDR_W-1:0] addr_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign empty    = (count == '0);
  assign full     = (count == (PTR_W + 1)'(DEPTH));
  assign pop_cmd  = cmd_q[rd_ptr];
  assign pop_addr = addr_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr]  <= push_cmd;
      addr_q[wr_ptr] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

// ----- sv/frf_back.sv -----
module frf_back
  import frf_pkg::*;
#(
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop,
  input  cmd_t              pop_cmd,
  input  logic [ADDR_W-1:0] pop_addr,
  output logic              result_valid,
  output logic [7:0]        pixel_out,
  output logic [7:0]        height,
  output logic [7:0]        width,
  output logic              out_of_range
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [7:0] frame_mem [DEPTH];
  logic [7:0] rd_data;
  logic       oor_q;

  always_ff @(posedge clk) begin
    if (pop && !pop_cmd.is_read) begin
      frame_mem[pop_addr] <= pop_cmd.pixel;
    end
    if (pop && pop_cmd.is_read) begin
      rd_data <= frame_mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= pop && pop_cmd.is_read;
    end
    if (pop && pop_cmd.is_read) begin
      oor_q  <= pop_cmd.oor;
      height <= pop_cmd.height;
      width  <= pop_cmd.width;
    end
  end

  assign out_of_range = oor_q;
  assign pixel_out    = oor_q ? 8'd0 : rd_data;

endmodule

// ----- sv/frame_rotate_flip.sv -----
// frame_rotate_flip holds one frame of 8-bit pixels in the orientation in which it was
// loaded and serves rotated or mirrored views of it without ever moving a pixel. A write
// request stores a pixel at a loaded-frame row and column, a transform request updates a
// three-bit orientation, and a read request maps a transformed-frame position
// back to the stored address and returns the pixel with the current height and width.
// One request is taken per clock cycle while busy is low. A read result appears on the
// result ports after passing through the request queue and then the registered read of
// the frame memory, which has a single port shared by writes and reads. The result is
// shown for exactly one cycle with result_valid high and cannot be held off, so the back
// end drains the queue every cycle and busy does not rise in normal use. The frame memory
// has no reset and needs no clearing pass; reading a pixel that was never written
// returns an arbitrary value. Configuration writes are always taken (cfg_ready is high)
// and must only be issued while no request is in flight.
module frame_rotate_flip
  import frf_pkg::*;
#(
  parameter int unsigned MAX_DIM = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [6:0]           row,
  input  logic [6:0]           col,
  input  logic [7:0]           pixel,
  input  logic [1:0]           op,
  output logic                 result_valid,
  output logic [7:0]           pixel_out,
  output logic [7:0]           height,
  output logic [7:0]           width,
  output logic                 out_of_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // Each stored coordinate gets enough bits for the largest frame side.
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W = 2 * IDX_W;

  logic [7:0]        rows;
  logic [7:0]        cols;
  logic              accept;
  logic              push;
  cmd_t              push_cmd;
  logic [ADDR_W-1:0] push_addr;
  logic              pop;
  cmd_t              pop_cmd;
  logic [ADDR_W-1:0] pop_addr;
  logic              q_empty;
  logic              q_full;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !busy;

  // Loaded-frame dimensions. Out-of-range values are clamped in the front end.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= DIM_RESET;
      cols <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: rows <= cfg_data;
        REG_COLS: cols <= cfg_data;
        default: begin
          rows <= rows;
        end
      endcase
    end
  end

  // The front end classifies each request, applies transforms to the
  // orientation, and turns reads into stored addresses.
  frf_front #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .row       (row),
    .col       (col),
    .pixel     (pixel),
    .op        (op),
    .rows      (rows),
    .cols      (cols),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr)
  );

  frf_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .pop_addr  (pop_addr),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The back end never stalls, so it takes a queued request every cycle.
  assign pop = !q_empty;

  frf_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop          (pop),
    .pop_cmd      (pop_cmd),
    .pop_addr     (pop_addr),
    .result_valid (result_valid),
    .pixel_out    (pixel_out),
    .height       (height),
    .width        (width),
    .out_of_range (out_of_range)
  );

  // A result always comes from a read request taken out of the queue in the previous cycle.
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(pop && pop_cmd.is_read))
    else $error("result strobe without a queued read");

  // An accepted read is answered once it has passed the queue and the registered memory read.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == REQ_READ)) |-> ##2 result_valid)
    else $error("read result missing two cycles after acceptance");

  // A read outside the current frame returns a zero pixel.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_of_range) |-> (pixel_out == 8'd0))
    else $error("out-of-range read returned a nonzero pixel");

  // The queue drains every cycle, so it never fills up.
  a_never_full: assert property (@(posedge clk) disable iff (rst)
    !q_full)
    else $error("request queue filled up");

endmodule

// ----- dv/frf_checker.sv -----
`timescale 1ns / 1ps
module frf_checker
  import frf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [6:0]           row,
  input  logic [6:0]           col,
  input  logic [7:0]           pixel,
  input  logic [1:0]           op,
  input  logic                 result_valid,
  input  logic [7:0]           pixel_out,
  input  logic [7:0]           height,
  input  logic [7:0]           width,
  input  logic                 out_of_range,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);

  localparam int FRAME_DIM = 128;

  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] height;
    logic [7:0] width;
    logic       oor;
  } read_view_t;

  logic [7:0]  frame_mem [0:FRAME_DIM*FRAME_DIM-1];
  orient_t     view;
  logic [7:0]  rows_reg;
  logic [7:0]  cols_reg;
  read_view_t  pending_reads [$];
  int unsigned fails = 0;

  assign mismatches = fails;

  function automatic logic [7:0] clamp_dim(logic [7:0] v);
    if (v == 8'd0) return 8'd1;
    if (v > FRAME_DIM) return 8'(FRAME_DIM);
    return v;
  endfunction

  function automatic orient_t turned(orient_t o, logic [1:0] kind);
    orient_t n;
    n = o;
    case (kind)
      OP_ROT_CW: begin
        n.t  = !o.t;
        n.fr = o.fc;
        n.fc = !o.fr;
      end
      OP_ROT_CCW: begin
        n.t  = !o.t;
        n.fr = !o.fc;
        n.fc = o.fr;
      end
      OP_MIRROR: n.fc = !o.fc;
      OP_FLIP:   n.fr = !o.fr;
      default: ;
    endcase
    return n;
  endfunction

  // Maps a transformed-frame position back to the stored pixel.
  function automatic read_view_t look_up(logic [6:0] r, logic [6:0] c);
    logic [7:0] lr, lc, h, w, rp, cp, sr, sc;
    read_view_t v;
    lr = clamp_dim(rows_reg);
    lc = clamp_dim(cols_reg);
    h  = view.t ? lc : lr;
    w  = view.t ? lr : lc;
    v.height = h;
    v.width  = w;
    v.pixel  = 8'd0;
    v.oor    = 1'b1;
    if ({1'b0, r} < h && {1'b0, c} < w) begin
      rp = view.fr ? h - 8'd1 - {1'b0, r} : {1'b0, r};
      cp = view.fc ? w - 8'd1 - {1'b0, c} : {1'b0, c};
      sr = view.t ? cp : rp;
      sc = view.t ? rp : cp;
      v.pixel = frame_mem[{sr[6:0], sc[6:0]}];
      v.oor   = 1'b0;
    end
    return v;
  endfunction

  task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    read_view_t want;
    if (rst) begin
      view     = '0;
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      pending_reads.delete();
    end else begin
      // A result always belongs to an earlier request, so it is checked first.
      if (result_valid) begin
        if (pending_reads.size() == 0) begin
          $error("read result with no request waiting: pixel_out %0d", pixel_out);
          fails++;
        end else begin
          want = pending_reads.pop_front();
          compare_field("pixel_out", want.pixel, pixel_out);
          compare_field("height", want.height, height);
          compare_field("width", want.width, width);
          compare_field("out_of_range", {7'd0, want.oor}, {7'd0, out_of_range});
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: rows_reg = cfg_data;
          REG_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (req_type)
          REQ_WRITE:
            if ({1'b0, row} < clamp_dim(rows_reg) && {1'b0, col} < clamp_dim(cols_reg))
              frame_mem[{row, col}] = pixel;
          REQ_TRANSFORM: view = turned(view, op);
          REQ_READ: pending_reads.push_back(look_up(row, col));
          default: ;
        endcase
      end
    end
    outstanding <= pending_reads.size();
  end

endmodule

// ----- dv/frame_rotate_flip_tb.sv -----
`timescale 1ns / 1ps
module frame_rotate_flip_tb;
  import frf_pkg::*;

  localparam int FRAME_DIM = 128;

  // The block ignores the fourth request type and the two upper register indexes.
  localparam logic [1:0]           REQ_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [1:0]           req_type  = REQ_WRITE;
  logic [6:0]           row       = '0;
  logic [6:0]           col       = '0;
  logic [7:0]           pixel     = '0;
  logic [1:0]           op        = OP_ROT_CW;
  logic                 result_valid;
  logic [7:0]           pixel_out;
  logic [7:0]           height;
  logic [7:0]           width;
  logic                 out_of_range;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
  logic [7:0]           cfg_data  = '0;

  int unsigned mismatches;
  int unsigned outstanding;

  // The stimulus keeps its own picture of the frame: which stored pixels hold
  // a written value, the orientation and the raw register values. It needs
  // this only to aim reads at written pixels, since a pixel that was never
  // written reads back as an arbitrary value.
  orient_t    view     = '0;
  logic [7:0] rows_cfg = DIM_RESET;
  logic [7:0] cols_cfg = DIM_RESET;
  bit         written [0:FRAME_DIM*FRAME_DIM-1];
  int         filled [$];
  bit         steady   = 1'b0;
  int         n_write  = 0;
  int         n_turn   = 0;
  int         n_read   = 0;
  int         n_unused = 0;
  int         n_frame  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_rotate_flip #(
    .MAX_DIM(FRAME_DIM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .row          (row),
    .col          (col),
    .pixel        (pixel),
    .op           (op),
    .result_valid (result_valid),
    .pixel_out    (pixel_out),
    .height       (height),
    .width        (width),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frf_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .row          (row),
    .col          (col),
    .pixel        (pixel),
    .op           (op),
    .result_valid (result_valid),
    .pixel_out    (pixel_out),
    .height       (height),
    .width        (width),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Register values of zero act as one and values above the frame limit are clamped.
  function automatic int dim_of(logic [7:0] v);
    if (v == 8'd0) return 1;
    if (v > FRAME_DIM) return FRAME_DIM;
    return int'(v);
  endfunction

  // Orientation after one transform: a rotation swaps height and width and
  // moves the mirror bits around, a mirror or flip toggles one of them.
  function automatic orient_t next_view(orient_t o, logic [1:0] kind);
    orient_t n;
    n = o;
    case (kind)
      OP_ROT_CW: begin
        n.t  = !o.t;
        n.fr = o.fc;
        n.fc = !o.fr;
      end
      OP_ROT_CCW: begin
        n.t  = !o.t;
        n.fr = !o.fc;
        n.fc = o.fr;
      end
      OP_MIRROR: n.fc = !o.fc;
      OP_FLIP:   n.fr = !o.fr;
      default: ;
    endcase
    return n;
  endfunction

  // Most gaps are short, a few are long enough to empty the read pipeline.
  function automatic int pick_gap();
    int d;
    d = $urandom_range(99);
    if (d < 60) return 0;
    if (d < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Holds requests off until every read result has come back, then lets the
  // read pipeline settle, since writes and transforms give no result.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Drives one request and waits until the block takes it. Start stays high
  // when the next request follows at once, so it is never lowered and raised
  // within one time step.
  task automatic send(logic [1:0] kind, logic [6:0] r, logic [6:0] c,
                      logic [7:0] px, logic [1:0] o);
    int pause;
    start    <= 1'b1;
    req_type <= kind;
    row      <= r;
    col      <= c;
    pixel    <= px;
    op       <= o;
    do @(posedge clk); while (busy);
    case (kind)
      REQ_WRITE: begin
        n_write++;
        if (r < dim_of(rows_cfg) && c < dim_of(cols_cfg) && !written[{r, c}]) begin
          written[{r, c}] = 1'b1;
          filled.push_back(int'({r, c}));
        end
      end
      REQ_TRANSFORM: begin
        n_turn++;
        view = next_view(view, o);
      end
      REQ_READ: n_read++;
      default: n_unused++;
    endcase
    // Now and then the sender waits for every outstanding result.
    if (!steady && $urandom_range(99) == 0) begin
      drain();
    end else begin
      pause = steady ? 0 : pick_gap();
      if (pause > 0) begin
        start <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
  endtask

  // Reads the pixel stored at a loaded-frame position by asking for the
  // transformed position that maps onto it under the current orientation.
  task automatic read_stored(int sr, int sc);
    int h, w, rp, cp;
    h  = view.t ? dim_of(cols_cfg) : dim_of(rows_cfg);
    w  = view.t ? dim_of(rows_cfg) : dim_of(cols_cfg);
    rp = view.t ? sc : sr;
    cp = view.t ? sr : sc;
    send(REQ_READ, 7'(view.fr ? h - 1 - rp : rp), 7'(view.fc ? w - 1 - cp : cp),
         8'($urandom), 2'($urandom));
  endtask

  // A random read: either deliberately outside the current dimensions, or
  // aimed at a written pixel. When no written pixel turns up quickly, a write
  // inside the frame is sent instead.
  task automatic random_read();
    int lr, lc, h, w, a;
    bit found;
    lr = dim_of(rows_cfg);
    lc = dim_of(cols_cfg);
    h  = view.t ? lc : lr;
    w  = view.t ? lr : lc;
    a  = 0;
    found = 1'b0;
    if ($urandom_range(99) < 15 && (h < FRAME_DIM || w < FRAME_DIM)) begin
      if (h < FRAME_DIM && (w == FRAME_DIM || $urandom_range(1) == 1))
        send(REQ_READ, 7'($urandom_range(127, h)), 7'($urandom_range(127)),
             8'($urandom), 2'($urandom));
      else
        send(REQ_READ, 7'($urandom_range(127)), 7'($urandom_range(127, w)),
             8'($urandom), 2'($urandom));
      return;
    end
    for (int k = 0; k < 16 && !found; k++) begin
      if (k < 8)
        a = $urandom_range(lr - 1) * FRAME_DIM + $urandom_range(lc - 1);
      else if (filled.size() > 0)
        a = filled[$urandom_range(filled.size() - 1)];
      found = written[a[13:0]] && (a / FRAME_DIM) < lr && (a % FRAME_DIM) < lc;
    end
    if (found)
      read_stored(a / FRAME_DIM, a % FRAME_DIM);
    else
      send(REQ_WRITE, 7'($urandom_range(lr - 1)), 7'($urandom_range(lc - 1)),
           8'($urandom), 2'($urandom));
  endtask

  task automatic random_request();
    int dice, lr, lc;
    dice = $urandom_range(99);
    lr   = dim_of(rows_cfg);
    lc   = dim_of(cols_cfg);
    if (dice < 35) begin
      // Most writes land inside the loaded frame; the rest may be dropped.
      if ($urandom_range(4) != 0)
        send(REQ_WRITE, 7'($urandom_range(lr - 1)), 7'($urandom_range(lc - 1)),
             8'($urandom), 2'($urandom));
      else
        send(REQ_WRITE, 7'($urandom_range(127)), 7'($urandom_range(127)),
             8'($urandom), 2'($urandom));
    end else if (dice < 45) begin
      send(REQ_TRANSFORM, 7'($urandom), 7'($urandom), 8'($urandom),
           2'($urandom_range(3)));
    end else if (dice < 95) begin
      random_read();
    end else begin
      send(REQ_UNUSED, 7'($urandom), 7'($urandom), 8'($urandom), 2'($urandom));
    end
  endtask

  // One register write; valid stays high so writes can go back to back.
  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Sets a new frame size, followed by a write to an index that has no
  // register, which must leave both sizes alone. Only called while idle.
  task automatic set_frame(logic [7:0] r, logic [7:0] c);
    cfg_put(REG_ROWS, r);
    cfg_put(REG_COLS, c);
    cfg_put($urandom_range(1) == 1 ? REG_SPARE_HI : REG_SPARE_LO, 8'($urandom));
    cfg_valid <= 1'b0;
    rows_cfg = r;
    cols_cfg = c;
    n_frame++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on a 3 x 5 frame, so that rotations visibly swap the
    // dimensions. Corners and the centre first, then writes the block has to drop.
    set_frame(8'd3, 8'd5);
    send(REQ_WRITE, 0, 0, 8'h00, OP_ROT_CW);
    send(REQ_WRITE, 0, 4, 8'hFF, OP_FLIP);
    send(REQ_WRITE, 2, 0, 8'hA5, OP_MIRROR);
    send(REQ_WRITE, 2, 4, 8'h5A, OP_ROT_CCW);
    send(REQ_WRITE, 1, 2, 8'h3C, OP_ROT_CW);
    send(REQ_WRITE, 127, 127, 8'h77, OP_FLIP);
    send(REQ_WRITE, 3, 0, 8'h11, OP_ROT_CW);
    send(REQ_UNUSED, 127, 127, 8'hFF, OP_FLIP);
    // Reads in the loaded orientation, then reads past the height and past
    // both limits, which must flag out of range and still report the size.
    read_stored(0, 4);
    read_stored(2, 4);
    send(REQ_READ, 3, 0, 8'hFF, OP_FLIP);
    send(REQ_READ, 127, 127, 8'h00, OP_ROT_CW);
    // Every transform, mostly followed by reads through the new mapping.
    send(REQ_TRANSFORM, 0, 0, 8'h00, OP_ROT_CW);
    read_stored(0, 0);
    read_stored(2, 4);
    send(REQ_READ, 0, 3, 8'h00, OP_ROT_CW);
    send(REQ_TRANSFORM, 0, 0, 8'h00, OP_ROT_CCW);
    send(REQ_TRANSFORM, 0, 0, 8'h00, OP_MIRROR);
    read_stored(2, 0);
    send(REQ_TRANSFORM, 0, 0, 8'h00, OP_FLIP);
    read_stored(0, 4);
    // A write after transforms still uses loaded-frame coordinates, and the
    // read right behind it must see the new value.
    send(REQ_WRITE, 1, 1, 8'h81, OP_ROT_CW);
    read_stored(1, 1);
    send(REQ_TRANSFORM, 0, 0, 8'h00, OP_ROT_CW);
    read_stored(1, 2);

    // Random phases over a spread of frame sizes: both extremes, a single
    // pixel, one-wide strips, clamped register values and random sizes.
    // Every third phase starts without gaps, and in all phases stretches toggle.
    for (int p = 0; p < 9; p++) begin
      drain();
      case (p)
        0: set_frame(8'd128, 8'd128);
        1: set_frame(8'd1, 8'd128);
        2: set_frame(8'd128, 8'd1);
        3: set_frame(8'd0, 8'd255);
        4: set_frame(8'd1, 8'd1);
        5: set_frame(8'd2, 8'd200);
        default: set_frame(8'($urandom_range(128, 1)), 8'($urandom_range(128, 1)));
      endcase
      steady = (p % 3 == 2);
      for (int k = 0; k < 215; k++) begin
        if ($urandom_range(49) == 0) steady = !steady;
        random_request();
      end
    end

    drain();
    $display("Covered %0d writes, %0d transforms, %0d reads, %0d unused-type requests",
             n_write, n_turn, n_read, n_unused);
    $display("over %0d frame sizes with %0d distinct pixels written.", n_frame, filled.size());
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Safety net: a lost result or a stuck handshake ends the run here.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/frf_pkg.sv
sv/frf_front.sv
sv/frf_queue.sv
sv/frf_back.sv
sv/frame_rotate_flip.sv
dv/frf_checker.sv
dv/frame_rotate_flip_tb.sv
